// ===== rtl/cmix_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmix_pkg
// Shared types and table generators for the sRGB linear color mix.
// ----------------------------------------------------------------------------
package cmix_pkg;

    localparam int CH_W     = 8;
    localparam int CHANNELS = 3;
    localparam int CODES    = 256;

    // all sRGB codes are expressed as num / CODE_DEN
    localparam logic [63:0] CODE_DEN = 64'd25500;
    localparam logic [63:0] Q31_ONE  = 64'd1 << 31;
    localparam logic [63:0] Q31_HALF = 64'd1 << 30;

    // divisors of the two decode segments, scaled to CODE_DEN
    localparam logic [63:0] LIN_DIV  = 64'd1292 * CODE_DEN;
    localparam logic [63:0] POW_DIV  = 64'd1055 * CODE_DEN;
    localparam logic [63:0] POW_HALF = POW_DIV / 64'd2;

    typedef logic [CH_W-1:0] chan_t;

    typedef struct packed {
        logic valid;
        logic inv;
    } ctl_t;

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + Q31_HALF) >> 31;
    endfunction

    function automatic logic [63:0] pow5_q31(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = qmul(r, r);
        r4 = qmul(r2, r2);
        return qmul(r4, r);
    endfunction

    function automatic logic [63:0] root5_q31(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = Q31_ONE;
        for (int i = 0; i < 33; i++)
        begin
            if (lo < hi)
            begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (pow5_q31(mid) <= v)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

    // linear light of code num / CODE_DEN, Q31
    function automatic logic [63:0] decode_q31(input logic [63:0] num);
        logic [63:0] u;
        logic [63:0] u2;
        if (num * 64'd100000 <= CODE_DEN * 64'd4045)
            return (num * 64'd100 * Q31_ONE + 64'd646 * CODE_DEN) / LIN_DIV;
        u = (((64'd1000 * num + 64'd55 * CODE_DEN) << 31) + POW_HALF) / POW_DIV;
        if (u > Q31_ONE)
            u = Q31_ONE;
        u2 = qmul(u, u);
        return qmul(u2, root5_q31(u2));
    endfunction

    function automatic logic [63:0] to_lin(input logic [63:0] x, input int lb);
        logic [63:0] v;
        logic [63:0] lmax;
        v    = (x + (64'd1 << (30 - lb))) >> (31 - lb);
        lmax = (64'd1 << lb) - 64'd1;
        return (v > lmax) ? lmax : v;
    endfunction

    function automatic logic [63:0] lin_entry(input int code, input int lb);
        return to_lin(decode_q31(64'd100 * 64'(code)), lb);
    endfunction

    function automatic logic [63:0] thr_entry(input int k, input int lb);
        if (k == 0)
            return 64'd0;
        return to_lin(decode_q31(64'd100 * 64'(k) - 64'd49), lb);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/cmix_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmix_decode
// Two stages: sRGB to linear table lookup, then per-channel linear sum.
// ----------------------------------------------------------------------------
module cmix_decode
    import cmix_pkg::*;
#(
    parameter int LINEAR_BITS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire ctl_t                 ctl_in,
    input  wire chan_t                first [CHANNELS],
    input  wire chan_t                second [CHANNELS],
    output ctl_t                      ctl_out,
    output logic [LINEAR_BITS:0]      sum_out [CHANNELS],
    output chan_t                     cnt_out [CHANNELS]
);

    typedef logic [LINEAR_BITS-1:0] lin_arr_t [CODES];

    function automatic lin_arr_t build_lin();
        lin_arr_t t;
        for (int i = 0; i < CODES; i++)
            t[i] = LINEAR_BITS'(lin_entry(i, LINEAR_BITS));
        return t;
    endfunction

    localparam lin_arr_t LIN_TAB = build_lin();

    ctl_t                   ctl1_reg;
    logic [LINEAR_BITS-1:0] la_reg [CHANNELS];
    logic [LINEAR_BITS-1:0] lb_reg [CHANNELS];
    chan_t                  inv1_reg [CHANNELS];
    ctl_t                   ctl2_reg;
    logic [LINEAR_BITS:0]   sum2_reg [CHANNELS];
    chan_t                  cnt2_reg [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                la_reg[c]   <= LIN_TAB[first[c]];
                lb_reg[c]   <= LIN_TAB[second[c]];
                inv1_reg[c] <= ~first[c];
                sum2_reg[c] <= {1'b0, la_reg[c]} + {1'b0, lb_reg[c]};
                // invert requests carry their answer; mix starts the search at zero
                cnt2_reg[c] <= ctl1_reg.inv ? inv1_reg[c] : '0;
            end
        end
    end

    assign ctl_out = ctl2_reg;
    assign sum_out = sum2_reg;
    assign cnt_out = cnt2_reg;

endmodule
`default_nettype wire

// ===== rtl/cmix_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmix_search
// One step of the threshold binary search: settles one bit of the code.
// ----------------------------------------------------------------------------
module cmix_search
    import cmix_pkg::*;
#(
    parameter int LINEAR_BITS = 16,
    parameter int BIT_POS     = 7
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire ctl_t                 ctl_in,
    input  wire logic [LINEAR_BITS:0] sum_in [CHANNELS],
    input  wire chan_t                cnt_in [CHANNELS],
    output ctl_t                      ctl_out,
    output logic [LINEAR_BITS:0]      sum_out [CHANNELS],
    output chan_t                     cnt_out [CHANNELS]
);

    typedef logic [LINEAR_BITS-1:0] thr_arr_t [CODES];

    function automatic thr_arr_t build_thr();
        thr_arr_t t;
        for (int i = 0; i < CODES; i++)
            t[i] = LINEAR_BITS'(thr_entry(i, LINEAR_BITS));
        return t;
    endfunction

    localparam thr_arr_t THR_TAB = build_thr();
    localparam chan_t    STEP    = chan_t'(1 << BIT_POS);

    ctl_t                 ctl_reg;
    logic [LINEAR_BITS:0] sum_reg [CHANNELS];
    chan_t                cnt_reg [CHANNELS];
    chan_t                trial   [CHANNELS];
    logic                 hit     [CHANNELS];

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            trial[c] = cnt_in[c] | STEP;
            // mean >= T[k] compared as sum >= 2*T[k]
            hit[c]   = !ctl_in.inv && (sum_in[c] >= {THR_TAB[trial[c]], 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= sum_in[c];
                cnt_reg[c] <= hit[c] ? trial[c] : cnt_in[c];
            end
        end
    end

    assign ctl_out = ctl_reg;
    assign sum_out = sum_reg;
    assign cnt_out = cnt_reg;

endmodule
`default_nettype wire

// ===== rtl/srgb_linear_color_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_linear_color_mix
// Gamma-correct average of two sRGB colors, or inversion of the first.
// ----------------------------------------------------------------------------
// Accepts one request per cycle while the output is not stalled and returns one
// result per request, in order. The pipeline holds a decode-table stage, a
// linear-sum stage and eight binary-search stages that each settle one bit of
// the re-encoded code against the constant threshold table. A stall at the
// output freezes the whole pipeline; nothing is dropped or repeated. Decode and
// threshold tables are built at elaboration from LINEAR_BITS (12 to 24).
// ----------------------------------------------------------------------------
module srgb_linear_color_mix
    import cmix_pkg::*;
#(
    parameter int LINEAR_BITS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic func,
    input  wire logic [7:0] first_red,
    input  wire logic [7:0] first_green,
    input  wire logic [7:0] first_blue,
    input  wire logic [7:0] second_red,
    input  wire logic [7:0] second_green,
    input  wire logic [7:0] second_blue,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [7:0] result_red,
    output logic [7:0] result_green,
    output logic [7:0] result_blue
);

    localparam int STEPS = CH_W;

    logic  en;
    ctl_t  ctl_in;
    chan_t first  [CHANNELS];
    chan_t second [CHANNELS];

    // stage chain: index 0 is the decode output, index STEPS the last search step
    ctl_t                 ctl [STEPS+1];
    logic [LINEAR_BITS:0] sum [STEPS+1][CHANNELS];
    chan_t                cnt [STEPS+1][CHANNELS];

    // global advance: the last stage is free or being taken
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    assign ctl_in.valid = in_valid;
    assign ctl_in.inv   = func;
    assign first[0]  = first_red;
    assign first[1]  = first_green;
    assign first[2]  = first_blue;
    assign second[0] = second_red;
    assign second[1] = second_green;
    assign second[2] = second_blue;

    cmix_decode #(
        .LINEAR_BITS (LINEAR_BITS)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl_in),
        .first   (first),
        .second  (second),
        .ctl_out (ctl[0]),
        .sum_out (sum[0]),
        .cnt_out (cnt[0])
    );

    // most significant code bit first
    for (genvar s = 0; s < STEPS; s++)
    begin : g_search
        cmix_search #(
            .LINEAR_BITS (LINEAR_BITS),
            .BIT_POS     (STEPS - 1 - s)
        ) u_search (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl[s]),
            .sum_in  (sum[s]),
            .cnt_in  (cnt[s]),
            .ctl_out (ctl[s+1]),
            .sum_out (sum[s+1]),
            .cnt_out (cnt[s+1])
        );
    end

    assign out_valid    = ctl[STEPS].valid;
    assign result_red   = cnt[STEPS][0];
    assign result_green = cnt[STEPS][1];
    assign result_blue  = cnt[STEPS][2];

    // input is taken exactly when the pipeline advances
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output space");

    // a request appears at the decode output only after an accepted input
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctl[0].valid) |-> $past(en))
        else $error("decode stage filled without an advance");

    // a frozen pipeline keeps the control and first-channel code of its middle stage
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(ctl[STEPS/2]) && $stable(cnt[STEPS/2][0]))
        else $error("mid pipeline moved during stall");

    // an inverted request keeps its first-channel code through the first search step
    a_inv_hold: assert property (@(posedge clk) disable iff (!rst_n)
        en && ctl[0].inv && ctl[0].valid |=> cnt[1][0] == $past(cnt[0][0]))
        else $error("search altered an inverted code");

endmodule
`default_nettype wire

// ===== dv/srgb_mix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_mix_checker
// Watches the input and output sides of the color mixer, predicts every result from the
// accepted requests and compares them in order, field by field.
// ----------------------------------------------------------------------------
module srgb_mix_checker
    import cmix_pkg::*;
#(
    parameter int LINEAR_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       func,
    input  logic [7:0] first_red,
    input  logic [7:0] first_green,
    input  logic [7:0] first_blue,
    input  logic [7:0] second_red,
    input  logic [7:0] second_green,
    input  logic [7:0] second_blue,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] result_red,
    input  logic [7:0] result_green,
    input  logic [7:0] result_blue,
    output int         errors,
    output int         pending
);

    localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } color_t;

    logic [63:0] linear_of_code [256];
    logic [63:0] code_threshold [256];
    color_t      colors_due [$];

    // Q31 product, rounded half up
    function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 30)) >> 31;
    endfunction

    // largest r whose chained fifth power stays at or below v
    function automatic logic [63:0] fifth_root(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] sq;
        lo = 0;
        hi = ONE_Q31;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            sq  = fix_mul(mid, mid);
            if (fix_mul(fix_mul(sq, sq), mid) <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // sRGB code num / den to linear light, rounded to LINEAR_BITS and saturated
    function automatic logic [63:0] srgb_to_linear(input logic [63:0] num,
                                                    input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] lim;
        if (num * 100000 <= den * 4045)
            q = (num * 100 * ONE_Q31 + 646 * den) / (1292 * den);
        else
        begin
            u = (((1000 * num + 55 * den) << 31) + (1055 * den) / 2) / (1055 * den);
            if (u > ONE_Q31)
                u = ONE_Q31;
            u2 = fix_mul(u, u);
            q  = fix_mul(u2, fifth_root(u2));
        end
        q   = (q + (64'd1 << (30 - LINEAR_BITS))) >> (31 - LINEAR_BITS);
        lim = (64'd1 << LINEAR_BITS) - 1;
        return (q > lim) ? lim : q;
    endfunction

    // count thresholds reached by the exact mean (sum against doubled threshold)
    function automatic chan_t blend_channel(input chan_t a, input chan_t b);
        logic [63:0] sum;
        int          n;
        sum = linear_of_code[a] + linear_of_code[b];
        n   = 0;
        for (int k = 1; k < 256; k++)
            if (sum >= 2 * code_threshold[k])
                n++;
        return chan_t'(n);
    endfunction

    initial
    begin
        for (int c = 0; c < 256; c++)
            linear_of_code[c] = srgb_to_linear(64'(c), 64'd255);
        code_threshold[0] = 0;
        for (int k = 1; k < 256; k++)
            code_threshold[k] = srgb_to_linear(64'(100 * k - 49), 64'd25500);
    end

    initial errors = 0;
    initial pending = 0;

    always @(posedge clk)
    begin
        color_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (func)
                    want = '{8'd255 - first_red, 8'd255 - first_green, 8'd255 - first_blue};
                else
                    want = '{blend_channel(first_red, second_red),
                             blend_channel(first_green, second_green),
                             blend_channel(first_blue, second_blue)};
                colors_due.insert(colors_due.size(), want);
            end
            if (out_valid && out_ready)
            begin
                if (colors_due.size() == 0)
                begin
                    $error("unexpected result %0d %0d %0d",
                           result_red, result_green, result_blue);
                    errors++;
                end
                else
                begin
                    want = colors_due.pop_front();
                    if (result_red !== want.red)
                    begin
                        $error("result_red: expected %0d, got %0d", want.red, result_red);
                        errors++;
                    end
                    if (result_green !== want.green)
                    begin
                        $error("result_green: expected %0d, got %0d", want.green, result_green);
                        errors++;
                    end
                    if (result_blue !== want.blue)
                    begin
                        $error("result_blue: expected %0d, got %0d", want.blue, result_blue);
                        errors++;
                    end
                end
            end
        end
        pending = colors_due.size();
    end

endmodule

// ===== dv/tb_srgb_linear_color_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_srgb_linear_color_mix
// Drives mix and invert requests into the color mixer with random gaps and
// output stalls; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_srgb_linear_color_mix;

    // request encoding of the func field
    localparam logic OP_MIX    = 1'b0;
    localparam logic OP_INVERT = 1'b1;

    localparam int RANDOM_REQUESTS = 1750;
    localparam int STALL_LIMIT     = 5000;  // cycles with no transfer at all
    localparam int DRAIN_CYCLES    = 30;    // pipeline is ten deep

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       func;
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] result_red;
    logic [7:0] result_green;
    logic [7:0] result_blue;

    int errors;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    srgb_linear_color_mix i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .first_red    (first_red),
        .first_green  (first_green),
        .first_blue   (first_blue),
        .second_red   (second_red),
        .second_green (second_green),
        .second_blue  (second_blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_red   (result_red),
        .result_green (result_green),
        .result_blue  (result_blue)
    );

    srgb_mix_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .first_red    (first_red),
        .first_green  (first_green),
        .first_blue   (first_blue),
        .second_red   (second_red),
        .second_green (second_green),
        .second_blue  (second_blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_red   (result_red),
        .result_green (result_green),
        .result_blue  (result_blue),
        .errors       (errors),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver: ready is redrawn every falling edge from the current idle rate
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog: any accepted request or result resets the quiet counter
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_srgb_linear_color_mix: errors");
            $finish;
        end
    end

    // One request: optional idle gap, then hold valid until it is taken.
    task automatic send_request(input logic op, input logic [7:0] ar, input logic [7:0] ag,
                                input logic [7:0] ab, input logic [7:0] br,
                                input logic [7:0] bg, input logic [7:0] bb);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= op;
        first_red    <= ar;
        first_green  <= ag;
        first_blue   <= ab;
        second_red   <= br;
        second_green <= bg;
        second_blue  <= bb;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random;
        logic [7:0] c;
        int         pick;
        pick = $urandom_range(9);
        c    = 8'($urandom);
        // mostly uniform colors; some pairs with equal red and blue, and some near the extremes
        if (pick < 6)
            send_request(($urandom_range(3) == 0) ? OP_INVERT : OP_MIX,
                         8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 8)
            send_request(OP_MIX, c, 8'($urandom), c, c, 8'($urandom), c);
        else
            send_request(1'($urandom_range(1)), 8'($urandom_range(10)),
                         8'd255 - 8'($urandom_range(10)),
                         8'($urandom_range(10)), 8'd255 - 8'($urandom_range(10)),
                         8'($urandom_range(10)), 8'($urandom_range(255)));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        func          = OP_MIX;
        first_red     = '0;
        first_green   = '0;
        first_blue    = '0;
        second_red    = '0;
        second_green  = '0;
        second_blue   = '0;
        quiet_cycles  = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, both operations, inversion ignoring second color
        send_request(OP_MIX,    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
        send_request(OP_MIX,    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_request(OP_MIX,    8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255);
        send_request(OP_MIX,    8'd10,  8'd11,  8'd1,   8'd10,  8'd11,  8'd1);
        send_request(OP_MIX,    8'd128, 8'd64,  8'd32,  8'd127, 8'd63,  8'd31);
        send_request(OP_MIX,    8'd254, 8'd1,   8'd128, 8'd255, 8'd0,   8'd128);
        send_request(OP_INVERT, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
        send_request(OP_INVERT, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_request(OP_INVERT, 8'd0,   8'd128, 8'd255, 8'd255, 8'd77,  8'd0);
        send_request(OP_INVERT, 8'd0,   8'd128, 8'd255, 8'd3,   8'd200, 8'd91);
        for (int b = 0; b < 8; b++)
            send_request(b[0] ? OP_INVERT : OP_MIX, 8'd1 << b, 8'd1 << b, 8'd1 << b,
                         ~(8'd1 << b), ~(8'd1 << b), ~(8'd1 << b));

        // random: slow sender / stalling receiver, then swapped, then full rate
        send_idle_pct = 30;
        recv_idle_pct = 55;
        for (int i = 0; i < RANDOM_REQUESTS / 3; i++)
            send_random();
        send_idle_pct = 55;
        recv_idle_pct = 30;
        for (int i = 0; i < RANDOM_REQUESTS / 3; i++)
            send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3); i++)
            send_random();
        @(negedge clk);
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_srgb_linear_color_mix: clean");
        else
            $display("tb_srgb_linear_color_mix: errors");
        $finish;
    end

endmodule
